### hw/rtl/pav_pkg.sv
// Package for the versioned array store: request and response payloads,
// command and status codes, and the control and status bundles that join
// the sequencer and the datapath. No dependencies.
package pav_pkg;

    typedef struct packed {
        logic [1:0]         command;
        logic [9:0]         version;
        logic [10:0]        position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [9:0]         new_version;
        logic [2:0]         status;
    } t_rsp;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_POS   = 3'd1;
    localparam logic [2:0] ST_BAD_VER   = 3'd2;
    localparam logic [2:0] ST_BUDGET    = 3'd3;
    localparam logic [2:0] ST_LATE_LOAD = 3'd4;

    localparam logic [10:0] LEN_RESET = 11'd1024;

    typedef struct packed {
        logic clr;
        logic capture;
        logic set_err;
        logic end_load;
        logic load_wr;
        logic root;
        logic step;
        logic leaf_wr;
        logic finish;
        logic push;
    } t_ctl;

    typedef struct packed {
        logic clr_last;
        logic is_ext;
        logic has_err;
        logic at_leaf;
        logic out_free;
    } t_sts;

endpackage

### hw/rtl/pav_ctrl.sv
// Sequencer of the versioned array store: clearing pass, request checks,
// tree walk steps and result hand-off. Depends on pav_pkg.
module pav_ctrl (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  pav_pkg::t_sts i_sts,
    output pav_pkg::t_ctl o_ctl
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_VREAD, S_ROOT, S_WALK, S_STEP, S_LEAF_RD, S_LEAF, S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_ctl.set_err  = 1'b1;
                o_ctl.end_load = i_sts.is_ext;
                o_ctl.load_wr  = !i_sts.is_ext && !i_sts.has_err;
                if (i_sts.is_ext && !i_sts.has_err) begin
                    n_state = S_VREAD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_VREAD: n_state = S_ROOT;
            S_ROOT: begin
                o_ctl.root = 1'b1;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (i_sts.at_leaf) begin
                    n_state = S_LEAF_RD;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_ctl.step = 1'b1;
                n_state = S_WALK;
            end
            S_LEAF_RD: begin
                o_ctl.leaf_wr = 1'b1;
                n_state = S_LEAF;
            end
            S_LEAF: begin
                o_ctl.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_ctl.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### hw/rtl/pav_dp.sv
// Datapath of the versioned array store: base values, node pool, version
// roots, walk registers and result register. Depends on pav_pkg.
module pav_dp #(
    parameter int ARRAY_MAX    = 1024,
    parameter int MAX_VERSIONS = 1024,
    parameter int NODE_POOL    = 16384
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [10:0]   i_cfg_wdata,
    input  pav_pkg::t_req i_in_data,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output pav_pkg::t_rsp o_out_data,
    input  pav_pkg::t_ctl i_ctl,
    output pav_pkg::t_sts o_sts
);

    localparam int NW = $clog2(NODE_POOL);
    localparam int PW = NW + 2;
    localparam int AW = $clog2(ARRAY_MAX);
    localparam int LW = $clog2(ARRAY_MAX + 1);
    localparam int VW = $clog2(MAX_VERSIONS + 1);
    localparam int VA = $clog2(MAX_VERSIONS);

    typedef logic [NW:0] t_ptr;
    typedef struct packed {
        t_ptr lft;
        t_ptr rgt;
    } t_link;

    logic [31:0] base_mem [ARRAY_MAX];
    t_link       link_mem [NODE_POOL];
    logic [31:0] leaf_mem [NODE_POOL];
    t_ptr        ver_mem  [MAX_VERSIONS];

    pav_pkg::t_req r_req;
    pav_pkg::t_rsp r_res;
    pav_pkg::t_rsp r_out;
    logic          r_ov;
    logic [10:0]   r_len;
    logic          r_loading;
    logic          r_tree_ok;
    logic [VW-1:0] r_nv;
    logic [PW-1:0] r_pool;
    logic [PW-1:0] r_cur;
    logic [PW-1:0] r_alloc;
    logic [AW-1:0] r_clr;
    logic [LW-1:0] r_lo;
    logic [LW-1:0] r_hi;
    t_ptr          r_p;
    t_ptr          r_root;
    t_ptr          r_vrd;
    t_link         r_lrd;
    logic [31:0]   r_leafrd;
    logic [31:0]   r_baserd;

    logic [LW-1:0] w_n;
    logic [LW:0]   w_2n1;
    logic          w_fits;
    logic          w_tree_ok;
    logic          w_pos_bad;
    logic [2:0]    w_err;
    logic [LW:0]   w_sum;
    logic [LW-1:0] w_m;
    logic          w_left;
    t_ptr          w_lft;
    t_ptr          w_rgt;
    t_ptr          w_child;
    logic          w_is_upd;
    logic          w_cur_ok;
    logic          w_fail;
    logic [AW-1:0] w_bidx;

    always_comb begin
        if (r_len == 11'd0) begin
            w_n = LW'(1);
        end else if (32'(r_len) > 32'(ARRAY_MAX)) begin
            w_n = LW'(ARRAY_MAX);
        end else begin
            w_n = LW'(r_len);
        end
    end

    assign w_2n1     = {w_n, 1'b0} - (LW+1)'(1);
    assign w_fits    = 32'(w_2n1) <= 32'(NODE_POOL);
    assign w_tree_ok = r_loading ? w_fits : r_tree_ok;
    assign w_pos_bad = (r_req.position == 11'd0) || (32'(r_req.position) > 32'(w_n));
    assign w_is_upd  = (r_req.command == pav_pkg::CMD_UPDATE);
    assign w_bidx    = AW'(r_req.position - 11'd1);

    always_comb begin
        w_err = pav_pkg::ST_OK;
        case (r_req.command)
            pav_pkg::CMD_LOAD: begin
                if (!r_loading) begin
                    w_err = pav_pkg::ST_LATE_LOAD;
                end else if (w_pos_bad) begin
                    w_err = pav_pkg::ST_BAD_POS;
                end
            end
            pav_pkg::CMD_UPDATE, pav_pkg::CMD_QUERY: begin
                if (w_pos_bad) begin
                    w_err = pav_pkg::ST_BAD_POS;
                end else if (32'(r_req.version) >= 32'(r_nv)) begin
                    w_err = pav_pkg::ST_BAD_VER;
                end else if (!w_tree_ok || (32'(r_nv) >= 32'(MAX_VERSIONS))) begin
                    w_err = pav_pkg::ST_BUDGET;
                end
            end
            default: w_err = pav_pkg::ST_OK;
        endcase
    end

    assign w_sum   = (LW+1)'(r_lo) + (LW+1)'(r_hi);
    assign w_m     = LW'(w_sum >> 1);
    assign w_left  = 32'(r_req.position) <= 32'(w_m);
    assign w_lft   = r_p[NW] ? {1'b1, NW'(0)} : r_lrd.lft;
    assign w_rgt   = r_p[NW] ? {1'b1, NW'(0)} : r_lrd.rgt;
    assign w_child = {1'b0, NW'(r_alloc)};
    assign w_cur_ok = 32'(r_cur) < 32'(NODE_POOL);
    assign w_fail  = 32'(r_alloc) > 32'(NODE_POOL);

    assign o_sts.clr_last = (r_clr == AW'(ARRAY_MAX - 1));
    assign o_sts.is_ext   = (r_req.command == pav_pkg::CMD_UPDATE) ||
                            (r_req.command == pav_pkg::CMD_QUERY);
    assign o_sts.has_err  = (w_err != pav_pkg::ST_OK);
    assign o_sts.at_leaf  = (r_lo >= r_hi);
    assign o_sts.out_free = !r_ov || i_out_ready;

    // memories
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            base_mem[r_clr] <= 32'd0;
        end else if (i_ctl.load_wr && (r_req.command == pav_pkg::CMD_LOAD)) begin
            base_mem[w_bidx] <= r_req.value;
        end
        r_baserd <= base_mem[w_bidx];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && w_is_upd && w_cur_ok) begin
            link_mem[NW'(r_cur)] <= w_left ? {w_child, w_rgt} : {w_lft, w_child};
        end
        r_lrd <= link_mem[r_p[NW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.leaf_wr && w_is_upd && w_cur_ok) begin
            leaf_mem[NW'(r_cur)] <= r_req.value;
        end
        r_leafrd <= leaf_mem[r_p[NW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.end_load && r_loading) begin
            ver_mem[VA'(0)] <= {1'b1, NW'(0)};
        end else if (i_ctl.finish && !(w_is_upd && w_fail)) begin
            ver_mem[VA'(r_nv)] <= w_is_upd ? {1'b0, NW'(r_pool)} : r_root;
        end
        r_vrd <= ver_mem[VA'(r_req.version)];
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_req <= i_in_data;
        end
        if (i_ctl.set_err) begin
            r_res <= '{read_value: '0, new_version: '0, status: w_err};
        end
        if (i_ctl.root) begin
            r_p     <= r_vrd;
            r_root  <= r_vrd;
            r_lo    <= LW'(1);
            r_hi    <= w_n;
            r_cur   <= r_pool;
            r_alloc <= r_pool + PW'(1);
        end
        if (i_ctl.step) begin
            r_p     <= w_left ? w_lft : w_rgt;
            r_cur   <= r_alloc;
            r_alloc <= r_alloc + PW'(1);
            if (w_left) begin
                r_hi <= w_m;
            end else begin
                r_lo <= w_m + LW'(1);
            end
        end
        if (i_ctl.finish) begin
            if (w_is_upd && w_fail) begin
                r_res <= '{read_value: '0, new_version: '0, status: pav_pkg::ST_BUDGET};
            end else begin
                r_res.read_value  <= w_is_upd ? 32'sd0 :
                                     (r_p[NW] ? r_baserd : r_leafrd);
                r_res.new_version <= 10'(r_nv);
                r_res.status      <= pav_pkg::ST_OK;
            end
        end
        if (i_ctl.push) begin
            r_out <= r_res;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov      <= 1'b0;
            r_len     <= pav_pkg::LEN_RESET;
            r_loading <= 1'b1;
            r_tree_ok <= 1'b0;
            r_nv      <= VW'(1);
            r_pool    <= '0;
            r_clr     <= '0;
        end else begin
            if (i_ctl.clr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg_we && r_loading) begin
                r_len <= i_cfg_wdata;
            end
            if (i_ctl.end_load && r_loading) begin
                r_loading <= 1'b0;
                r_tree_ok <= w_fits;
                if (w_fits) begin
                    r_pool <= PW'(w_2n1);
                end
            end
            if (i_ctl.finish && !(w_is_upd && w_fail)) begin
                r_nv <= r_nv + VW'(1);
                if (w_is_upd) begin
                    r_pool <= r_alloc;
                end
            end
            if (i_ctl.push) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pool) <= 32'(NODE_POOL))
        else $error("node pool count past its budget");

    a_ver_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_nv) <= 32'(MAX_VERSIONS) && r_nv != VW'(0))
        else $error("version count out of range");

    a_end_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.end_load |=> !r_loading)
        else $error("loading still open after first update or query");

    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.finish && !(w_is_upd && w_fail)) |=> r_nv == $past(r_nv) + VW'(1))
        else $error("version not published on commit");

endmodule

### hw/rtl/persistent_array_versions.sv
// Versioned array store, top level: sequencer plus datapath.
// Depends on pav_pkg, pav_ctrl and pav_dp.
//
// After reset the block sweeps the base value memory to zero, one entry per
// cycle, and takes no request until the sweep is done; configuration writes
// are taken throughout. A load, an unknown command or a request that fails
// its checks goes from the check state straight to the result hand-off. An
// update or query walks the tree with one node memory read per level.
// Version 0 is not built in the node pool: it is read straight from the base
// values, while its 2n-1 nodes are still charged against the pool budget.
module persistent_array_versions #(
    parameter int ARRAY_MAX    = 1024,
    parameter int MAX_VERSIONS = 1024,
    parameter int NODE_POOL    = 16384
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [10:0]   i_cfg_wdata,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pav_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pav_pkg::t_rsp o_out_data
);

    pav_pkg::t_ctl w_ctl;
    pav_pkg::t_sts w_sts;

    pav_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    pav_dp #(
        .ARRAY_MAX    (ARRAY_MAX),
        .MAX_VERSIONS (MAX_VERSIONS),
        .NODE_POOL    (NODE_POOL)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts)
    );

endmodule

### test/tb_persistent_array_versions.sv
// Testbench for persistent_array_versions: random and directed requests
// checked against a versioned-array predictor kept in the bench.
// Depends on pav_pkg and the persistent_array_versions RTL.
module tb_persistent_array_versions;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int LEN_MAX = 1024;
    localparam int VER_MAX = 1024;
    localparam int POOL_MAX = 16384;
    localparam int STALL_LIMIT = 8000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [10:0]   i_cfg_wdata = '0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    pav_pkg::t_req i_in_data = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    pav_pkg::t_rsp o_out_data;

    persistent_array_versions dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    pav_pkg::t_req pending_reqs[$];
    pav_pkg::t_rsp expected_rsps[$];
    int   errors = 0;
    int   reqs_taken = 0;
    int   rsps_taken = 0;

    // versioned array state
    logic [31:0] base_vals[LEN_MAX];
    int unsigned left_link[POOL_MAX];
    int unsigned right_link[POOL_MAX];
    logic [31:0] leaf_vals[POOL_MAX];
    int unsigned ver_root[VER_MAX];
    int unsigned ver_count = 1;
    int unsigned nodes_used = 0;
    int unsigned cfg_len = pav_pkg::LEN_RESET;
    bit          in_load = 1'b1;
    bit          tree_built = 1'b0;

    function automatic int unsigned clamp_len();
        if (cfg_len < 1) return 1;
        if (cfg_len > LEN_MAX) return LEN_MAX;
        return cfg_len;
    endfunction

    function automatic int unsigned grab_node();
        int unsigned k;
        k = nodes_used;
        nodes_used++;
        return (k < POOL_MAX) ? k : 0;
    endfunction

    function automatic void build_span(int unsigned node, int unsigned lo, int unsigned hi);
        int unsigned mid, a, b;
        if (lo >= hi) begin
            leaf_vals[node] = base_vals[(lo - 1) % LEN_MAX];
            return;
        end
        mid = (lo + hi) >> 1;
        a = grab_node();
        b = grab_node();
        left_link[node] = a;
        right_link[node] = b;
        build_span(a, lo, mid);
        build_span(b, mid + 1, hi);
    endfunction

    function automatic pav_pkg::t_rsp apply_request(pav_pkg::t_req r);
        pav_pkg::t_rsp rsp;
        int unsigned   n, lo, hi, mid, p, need, old, cur, child;
        rsp = '0;
        rsp.status = pav_pkg::ST_OK;
        if (r.command == pav_pkg::CMD_LOAD) begin
            if (!in_load) rsp.status = pav_pkg::ST_LATE_LOAD;
            else if (r.position < 1 || r.position > clamp_len())
                rsp.status = pav_pkg::ST_BAD_POS;
            else base_vals[(r.position - 1) % LEN_MAX] = r.value;
        end else if (r.command == pav_pkg::CMD_UPDATE || r.command == pav_pkg::CMD_QUERY) begin
            if (in_load) begin
                in_load = 1'b0;
                n = clamp_len();
                tree_built = (2 * n - 1 <= POOL_MAX);
                if (tree_built) begin
                    nodes_used = 0;
                    ver_root[0] = grab_node();
                    build_span(ver_root[0], 1, n);
                end
            end
            n = clamp_len();
            if (r.position < 1 || r.position > n) rsp.status = pav_pkg::ST_BAD_POS;
            else if (r.version >= ver_count) rsp.status = pav_pkg::ST_BAD_VER;
            else if (!tree_built || ver_count >= VER_MAX) rsp.status = pav_pkg::ST_BUDGET;
            else if (r.command == pav_pkg::CMD_QUERY) begin
                p = ver_root[r.version];
                lo = 1;
                hi = n;
                while (lo < hi) begin
                    mid = (lo + hi) >> 1;
                    if (r.position <= mid) begin p = left_link[p]; hi = mid; end
                    else begin p = right_link[p]; lo = mid + 1; end
                end
                rsp.read_value = leaf_vals[p];
                rsp.new_version = ver_count;
                ver_root[ver_count] = ver_root[r.version];
                ver_count++;
            end else begin
                need = 1;
                lo = 1;
                hi = n;
                while (lo < hi) begin
                    mid = (lo + hi) >> 1;
                    if (r.position <= mid) hi = mid; else lo = mid + 1;
                    need++;
                end
                if (nodes_used + need > POOL_MAX) rsp.status = pav_pkg::ST_BUDGET;
                else begin
                    old = ver_root[r.version];
                    cur = grab_node();
                    rsp.new_version = ver_count;
                    ver_root[ver_count] = cur;
                    lo = 1;
                    hi = n;
                    while (lo < hi) begin
                        mid = (lo + hi) >> 1;
                        child = grab_node();
                        if (r.position <= mid) begin
                            right_link[cur] = right_link[old];
                            left_link[cur] = child;
                            old = left_link[old];
                            hi = mid;
                        end else begin
                            left_link[cur] = left_link[old];
                            right_link[cur] = child;
                            old = right_link[old];
                            lo = mid + 1;
                        end
                        cur = child;
                    end
                    leaf_vals[cur] = r.value;
                    ver_count++;
                end
            end
        end
        return rsp;
    endfunction

    function automatic pav_pkg::t_req make_req(logic [1:0] cmd, int unsigned ver,
                                               int unsigned pos, logic [31:0] val);
        pav_pkg::t_req r;
        r.command = cmd;
        r.version = ver[9:0];
        r.position = pos[10:0];
        r.value = val;
        return r;
    endfunction

    // sender
    always @(posedge i_clk) begin : req_driver
        bit calm;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_rsps.push_back(apply_request(i_in_data));
                reqs_taken++;
            end
            if (!(i_in_valid && !o_in_ready)) begin
                calm = (reqs_taken >= 500 && reqs_taken < 650);
                if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 27)) begin
                    i_in_data <= pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off
    int  hold_cycles = 0;
    bit  hold_done = 1'b0;
    always @(posedge i_clk) begin : rsp_ready
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && rsps_taken >= 200) begin
            hold_done <= 1'b1;
            hold_cycles <= 300;
            i_out_ready <= 1'b0;
        end else if (rsps_taken >= 500 && rsps_taken < 650) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= 27);
        end
    end

    always @(posedge i_clk) begin : rsp_checker
        pav_pkg::t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            rsps_taken++;
            if (expected_rsps.size() == 0) begin
                $error("unexpected response %p", o_out_data);
                errors++;
            end else begin
                want = expected_rsps.pop_front();
                if (o_out_data.read_value !== want.read_value) begin
                    $error("read_value exp %0d got %0d", want.read_value, o_out_data.read_value);
                    errors++;
                end
                if (o_out_data.new_version !== want.new_version) begin
                    $error("new_version exp %0d got %0d", want.new_version,
                           o_out_data.new_version);
                    errors++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, o_out_data.status);
                    errors++;
                end
            end
        end
    end

    int stall_count = 0;
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (pending_reqs.size() == 0 && !i_in_valid && expected_rsps.size() == 0)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || i_in_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_len(int unsigned v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v[10:0];
        if (in_load) cfg_len = v & 11'h7FF;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned n, roll, pos, ver;
        logic [1:0]  cmd;
        logic [31:0] val;
        int unsigned picks[6];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_len(0);
        pending_reqs.push_back(make_req(pav_pkg::CMD_LOAD, 0, 1, 32'h7FFF_FFFF));
        pending_reqs.push_back(make_req(pav_pkg::CMD_LOAD, 0, 2, 32'h1));
        pending_reqs.push_back(make_req(pav_pkg::CMD_LOAD, 1023, 0, 32'h2));
        drain();

        write_len(2047);
        pending_reqs.push_back(make_req(pav_pkg::CMD_LOAD, 0, 1024, 32'h8000_0000));
        pending_reqs.push_back(make_req(pav_pkg::CMD_LOAD, 0, 1025, 32'h3));
        pending_reqs.push_back(make_req(pav_pkg::CMD_LOAD, 0, 2047, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(CMD_NONE, 1023, 2047, 32'hFFFF_FFFF));
        drain();

        picks = '{1, 2, 3, 17, 1024, $urandom_range(4, 64)};
        write_len(1);
        write_len(1024);
        write_len(picks[$urandom_range(0, 5)]);
        n = clamp_len();
        if (n <= 64) begin
            for (int i = 1; i <= n; i++)
                pending_reqs.push_back(make_req(pav_pkg::CMD_LOAD, 0, i, $urandom));
        end else begin
            pending_reqs.push_back(make_req(pav_pkg::CMD_LOAD, 0, 1, 32'h8000_0000));
            pending_reqs.push_back(make_req(pav_pkg::CMD_LOAD, 0, n, 32'h7FFF_FFFF));
            for (int i = 0; i < 60; i++)
                pending_reqs.push_back(make_req(pav_pkg::CMD_LOAD, 0, $urandom_range(1, n),
                                                $urandom));
        end
        pending_reqs.push_back(make_req(pav_pkg::CMD_LOAD, 0, n + 1, 32'h5));
        drain();

        pending_reqs.push_back(make_req(pav_pkg::CMD_QUERY, 0, 1, 0));
        pending_reqs.push_back(make_req(pav_pkg::CMD_QUERY, 0, n, 0));
        pending_reqs.push_back(make_req(pav_pkg::CMD_UPDATE, 0, 1, 32'h8000_0000));
        pending_reqs.push_back(make_req(pav_pkg::CMD_UPDATE, 3, n, 32'h7FFF_FFFF));
        pending_reqs.push_back(make_req(pav_pkg::CMD_QUERY, 3, 1, 0));
        pending_reqs.push_back(make_req(pav_pkg::CMD_QUERY, 4, n, 0));
        pending_reqs.push_back(make_req(pav_pkg::CMD_QUERY, 1023, 1, 0));
        pending_reqs.push_back(make_req(pav_pkg::CMD_QUERY, 7, 1, 0));
        pending_reqs.push_back(make_req(pav_pkg::CMD_UPDATE, 0, 0, 32'h9));
        pending_reqs.push_back(make_req(pav_pkg::CMD_UPDATE, 1023, n + 1, 32'h9));
        pending_reqs.push_back(make_req(pav_pkg::CMD_QUERY, 0, 2047, 0));
        pending_reqs.push_back(make_req(pav_pkg::CMD_LOAD, 0, 1, 32'h9));
        pending_reqs.push_back(make_req(CMD_NONE, 5, 5, 32'h9));
        drain();
        write_len(5);

        for (int chunk = 0; chunk < 17; chunk++) begin
            n = clamp_len();
            for (int i = 0; i < 50; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 44) cmd = pav_pkg::CMD_UPDATE;
                else if (roll < 90) cmd = pav_pkg::CMD_QUERY;
                else if (roll < 95) cmd = pav_pkg::CMD_LOAD;
                else cmd = CMD_NONE;
                roll = $urandom_range(0, 99);
                if (roll < 94) pos = $urandom_range(1, n);
                else if (roll < 96) pos = 0;
                else if (roll < 98) pos = n + 1;
                else pos = $urandom_range(0, 2047);
                if ($urandom_range(0, 99) < 93) ver = $urandom_range(0, ver_count - 1);
                else ver = $urandom_range(0, 1023);
                roll = $urandom_range(0, 9);
                val = (roll == 0) ? 32'h8000_0000 : (roll == 1) ? 32'h7FFF_FFFF : $urandom;
                pending_reqs.push_back(make_req(cmd, ver, pos, val));
            end
            drain();
        end

        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule

### persistent_array_versions.f
hw/rtl/pav_pkg.sv
hw/rtl/pav_ctrl.sv
hw/rtl/pav_dp.sv
hw/rtl/persistent_array_versions.sv
test/tb_persistent_array_versions.sv
